// ===== hdl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for the integer to ASCII converter
// Value width, counter widths, controller states and the digit encoder.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_BITS = 16;
    localparam int STEP_W     = $clog2(VALUE_BITS);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    // digit 0..35 to '0'..'9', 'a'..'z'
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-RADIX_W){1'b0}}, d};
        if (d > 6'd9) begin
            digit_char = CHAR_A + dx - 8'd10;
        end else begin
            digit_char = CHAR_ZERO + dx;
        end
    endfunction

endpackage

// ===== hdl/integer_to_ascii_radix.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: 16-bit integer to ASCII digits, base 2 to 36
// Repeated bit-serial division by the base; digits are stacked and then
// sent most significant first, one character per output transfer.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | role
//  --------+----------------------------------+---------------------------
//  cfg     | i_cfg_valid/o_cfg_ready, radix   | base register write
//  in      | i_in_valid/o_in_ready, value     | number to convert
//  out     | o_out_valid/i_out_ready, char,   | one character per transfer,
//          | last                             | last flags the final one
//
//  Each digit is one division in the bit-serial divider, and each character
//  sent is one output transfer. The longest item is base 2, 16 digits.
//  Reset sets the base to 10 and returns the controller to idle.
//  A stalled sink holds the current character; no new item is taken until
//  the final character of the current one has been transferred.
//
module integer_to_ascii_radix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [itoa_pkg::RADIX_W-1:0]  i_cfg_radix,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [itoa_pkg::VALUE_BITS-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [itoa_pkg::CHAR_W-1:0]   o_character,
    output logic                          o_last
);
    import itoa_pkg::*;

    t_state             r_state, n_state;
    logic [RADIX_W-1:0] r_radix;
    logic               r_neg, n_neg;

    logic [RADIX_W-1:0]    eff_radix;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [RADIX_W-1:0]    div_rem;

    logic                  push, pop;
    logic [CHAR_W-1:0]     top_char;
    logic [CNT_W-1:0]      count;

    // base register; always ready, the source writes it only between numbers (user rule, not enforced here)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_radix;
        end
    end

    // out-of-range bases clamp to the nearest legal one
    always_comb begin
        priority if (r_radix < RADIX_MIN) begin
            eff_radix = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            eff_radix = RADIX_MAX;
        end else begin
            eff_radix = r_radix;
        end
    end

    // sign only in base 10; the most negative value negates to itself,
    // which read unsigned is the correct magnitude
    assign in_neg = (eff_radix == RADIX_DEC) && i_value[VALUE_BITS-1];
    assign in_mag = in_neg ? VALUE_BITS'(~i_value + 1'b1) : VALUE_BITS'(i_value);

    always_comb begin
        n_state      = r_state;
        n_neg        = r_neg;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_character  = top_char;
        o_last       = 1'b0;
        div_start    = 1'b0;
        div_dividend = div_quot;
        push         = 1'b0;
        pop          = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                div_dividend = in_mag;
                if (i_in_valid) begin
                    div_start = 1'b1;
                    n_neg     = in_neg;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    push = 1'b1;
                    // zero quotient ends the digit loop; zero input gives '0'
                    if (div_quot == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (r_neg) begin
                    o_character = CHAR_MINUS;
                    if (i_out_ready) begin
                        n_neg = 1'b0;
                    end
                end else begin
                    o_last = (count == CNT_W'(1));
                    if (i_out_ready) begin
                        pop = 1'b1;
                        if (count == CNT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_neg   <= n_neg;
        end
    end

    itoa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (eff_radix),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    itoa_stack u_stack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_digit    (div_rem),
        .i_pop      (pop),
        .o_top_char (top_char),
        .o_count    (count)
    );

endmodule

// ===== hdl/itoa_div.sv =====
// ----------------------------------------------------------------------------
// itoa_div: bit-serial restoring divider
// One quotient bit per cycle; VALUE_BITS quotient bits per division.
// ----------------------------------------------------------------------------
module itoa_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [itoa_pkg::VALUE_BITS-1:0] i_dividend,
    input  logic [itoa_pkg::RADIX_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [itoa_pkg::VALUE_BITS-1:0] o_quotient,
    output logic [itoa_pkg::RADIX_W-1:0]    o_remainder
);
    import itoa_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [STEP_W-1:0]     r_cnt, n_cnt;
    logic [VALUE_BITS-1:0] r_q, n_q;
    logic [RADIX_W-1:0]    r_rem, n_rem;

    logic [RADIX_W:0] shifted;
    logic [RADIX_W:0] divisor_x;
    logic             ge;

    assign shifted   = {r_rem, r_q[VALUE_BITS-1]};
    assign divisor_x = {1'b0, i_divisor};
    assign ge        = (shifted >= divisor_x);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_q   = {r_q[VALUE_BITS-2:0], ge};
            n_rem = ge ? RADIX_W'(shifted - divisor_x) : RADIX_W'(shifted);
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == STEP_W'(VALUE_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

// ===== hdl/itoa_stack.sv =====
// ----------------------------------------------------------------------------
// itoa_stack: digit LIFO
// Digits arrive least significant first and leave most significant first.
// Shift-register stack: the top of stack always sits in entry 0.
// ----------------------------------------------------------------------------
module itoa_stack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [itoa_pkg::RADIX_W-1:0]  i_digit,
    input  logic                          i_pop,
    output logic [itoa_pkg::CHAR_W-1:0]   o_top_char,
    output logic [itoa_pkg::CNT_W-1:0]    o_count
);
    import itoa_pkg::*;

    logic [RADIX_W-1:0] r_mem [VALUE_BITS];
    logic [CNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_push) begin
            r_count <= r_count + 1'b1;
        end else if (i_pop) begin
            r_count <= r_count - 1'b1;
        end
        // push shifts down, pop shifts up
        if (i_push) begin
            r_mem[0] <= i_digit;
            for (int i = 1; i < VALUE_BITS; i++) begin
                r_mem[i] <= r_mem[i-1];
            end
        end else if (i_pop) begin
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
                r_mem[i] <= r_mem[i+1];
            end
        end
    end

    assign o_top_char = digit_char(r_mem[0]);
    assign o_count    = r_count;

endmodule

// ===== hdl/itoa_checker.sv =====
// ----------------------------------------------------------------------------
// itoa_checker: port-level checks for integer_to_ascii_radix
// Watches the handshakes and the character stream over time.
// ----------------------------------------------------------------------------
module itoa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [itoa_pkg::CHAR_W-1:0]  o_character,
    input logic                         o_last
);
    import itoa_pkg::*;

    // stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_character)
                                        && $stable(o_last))
        else $error("stalled output changed");

    // one number at a time: no intake while characters are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready))
        else $error("input taken while output pending");

    // conversion takes time after an input transfer
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready && !o_out_valid)
        else $error("no conversion interval after input transfer");

    // a sign never ends a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_character == CHAR_MINUS |-> !o_last)
        else $error("minus sign flagged last");

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_character (o_character),
    .o_last      (o_last)
);
